// ===== rtl/sldf_pkg.sv =====
// ----------------------------------------------------------------------------
// sldf_pkg: shared types and constants of the sync/length frame deframer
// Sequencer and parse phase codes, the register map and the result beat.
// ----------------------------------------------------------------------------
package sldf_pkg;

	// Register map: register i at byte address 4*i
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [0:0] REG_SYNC_WORD   = 1'b0;
	localparam logic [0:0] REG_MAX_PAYLOAD = 1'b1;

	localparam logic [15:0] SYNC_WORD_RST   = 16'h0000;
	localparam logic [6:0]  MAX_PAYLOAD_RST = 7'd64;
	localparam logic [15:0] LOSS_SAT        = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_CHECK  = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_WAIT,
		ST_DISPATCH,
		ST_ADDR_LO,
		ST_ADDR_HI,
		ST_EVAL,
		ST_PUT
	} seq_state_t;

	typedef struct packed {
		logic [15:0] sync_word;
		logic [6:0]  max_payload_bytes;
	} cfg_t;

	typedef struct packed {
		logic [15:0] word_offset;
		logic [15:0] payload_word;
		logic        word_present;
		logic [15:0] lost_bytes;
		logic        loss_known;
		logic        frame_last;
	} result_t;

endpackage

// ===== rtl/sync_length_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// sync_length_frame_deframer_top: sync word / length frame deframer
// Buffers a byte stream in a ring RAM, hunts for the sync word, checks the
// trailing sync word and streams out the payload words of accepted frames.
// ----------------------------------------------------------------------------
//
//  channel   | handshake            | beat content
//  ----------+----------------------+-----------------------------------------
//  input     | in_valid / in_ready  | stream_byte
//  output    | out_valid / out_ready| word_offset, payload_word, word_present,
//            |                      | lost_bytes, loss_known, frame_last
//  config    | APB psel/penable     | sync_word @0x0, max_payload_bytes @0x4
//
//  Steps: a byte beat that does not complete a parse step is accepted, then
//  dispatched. Each parse step reads two ring bytes through the single
//  registered read port of the ring RAM (address low, address high, evaluate):
//  a slid byte in the hunt and a sync check are a step each, a length header
//  reads two byte pairs, and each payload word is a step followed by an emit.
//  Reset: arst_n clears the sequencer, pointers, counters and output valid;
//  the ring RAM is not cleared, the parser only reads bytes it has written.
//  Stalls: the output register holds a beat until taken; the sequencer waits
//  in its emit step while the register is full, and accepts the next byte
//  while the last beat of a frame is still waiting.
//
module sync_length_frame_deframer_top import sldf_pkg::*; #(
	parameter int RING_BYTES      = 128,
	parameter int MAX_FRAME_WORDS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// APB configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// byte stream in
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            stream_byte,
	// result beats out
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           word_offset,
	output logic [15:0]           payload_word,
	output logic                  word_present,
	output logic [15:0]           lost_bytes,
	output logic                  loss_known,
	output logic                  frame_last
);

	localparam int PTR_W = $clog2(RING_BYTES);

	cfg_t             cfg;
	result_t          result;
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;

	// Register file: the user must write it only while the deframer is idle; the block does not enforce this
	sldf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Byte ring: writes land at accept, reads follow in later parse cycles,
	// so the sequencer itself keeps a write and a read of one entry apart
	sldf_ram #(
		.WIDTH (8),
		.DEPTH (RING_BYTES)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Parse sequencer and output register
	sldf_parser #(
		.RING_BYTES      (RING_BYTES),
		.MAX_FRAME_WORDS (MAX_FRAME_WORDS)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.stream_byte (stream_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.result      (result),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	// Unpack the result beat onto its field ports
	assign word_offset  = result.word_offset;
	assign payload_word = result.payload_word;
	assign word_present = result.word_present;
	assign lost_bytes   = result.lost_bytes;
	assign loss_known   = result.loss_known;
	assign frame_last   = result.frame_last;

endmodule

// ===== rtl/sldf_ram.sv =====
// ----------------------------------------------------------------------------
// sldf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sldf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/sldf_cfg.sv =====
// ----------------------------------------------------------------------------
// sldf_cfg: APB register file
// Holds the sync word and the payload size limit.
// ----------------------------------------------------------------------------
module sldf_cfg import sldf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	logic [0:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_word         <= SYNC_WORD_RST;
			cfg_q.max_payload_bytes <= MAX_PAYLOAD_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_SYNC_WORD:   cfg_q.sync_word         <= pwdata[15:0];
				REG_MAX_PAYLOAD: cfg_q.max_payload_bytes <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SYNC_WORD:   prdata = {16'b0, cfg_q.sync_word};
			REG_MAX_PAYLOAD: prdata = {25'b0, cfg_q.max_payload_bytes};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== rtl/sldf_parser.sv =====
// ----------------------------------------------------------------------------
// sldf_parser: ring write, parse sequencer and output register
// Reads the byte ring two bytes per step and walks the frame phases.
// ----------------------------------------------------------------------------
module sldf_parser import sldf_pkg::*; #(
	parameter int RING_BYTES      = 128,
	parameter int MAX_FRAME_WORDS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    stream_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output result_t                       result,
	output logic                          ram_we,
	output logic [$clog2(RING_BYTES)-1:0] ram_waddr,
	output logic [7:0]                    ram_wdata,
	output logic [$clog2(RING_BYTES)-1:0] ram_raddr,
	input  logic [7:0]                    ram_rdata
);

	localparam int PTR_W = $clog2(RING_BYTES);
	localparam int CNT_W = $clog2(RING_BYTES + 1);
	localparam logic [CNT_W:0] RING_C  = (CNT_W+1)'(RING_BYTES);
	localparam logic [16:0]    MAXW_C  = 17'(MAX_FRAME_WORDS);
	localparam logic [17:0]    LIMIT_C = 18'(RING_BYTES - 4);

	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
		input logic [CNT_W-1:0] n);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(p) + (CNT_W+1)'(n);
		if (sum >= RING_C) begin
			sum = sum - RING_C;
		end
		return PTR_W'(sum);
	endfunction

	seq_state_t       state_q, state_d;
	phase_t           phase_q;
	logic [PTR_W-1:0] rp_q, fsp_q;
	logic [CNT_W-1:0] avail_q, off_q, held_len_q;
	logic [15:0]      held_offset_q, loss_q;
	logic             first_q, sub_q, out_valid_q;
	logic [7:0]       lo_q;
	logic [15:0]      put_word_q;
	logic             put_last_q;
	result_t          out_q;

	logic [15:0] word;
	logic [16:0] nbytes;
	logic        sync_hit, len_reject, enough, load, ring_full, len_zero, off_last;

	assign word      = {ram_rdata, lo_q};
	assign sync_hit  = (word == cfg.sync_word);
	assign nbytes    = {word, 1'b0};
	assign len_reject = (nbytes > 17'(cfg.max_payload_bytes)) || ({1'b0, word} > MAXW_C) ||
		((18'(nbytes) + 18'd2) > LIMIT_C);
	assign ring_full = ((CNT_W+1)'(avail_q) >= RING_C);
	assign len_zero  = (held_len_q == '0);
	assign off_last  = ((CNT_W+1)'(off_q) + (CNT_W+1)'(2) == (CNT_W+1)'(held_len_q));

	always_comb begin
		case (phase_q)
			PH_LENGTH: enough = (avail_q >= CNT_W'(4));
			PH_CHECK:  enough = ((CNT_W+1)'(avail_q) >= (CNT_W+1)'(held_len_q) + (CNT_W+1)'(2));
			default:   enough = (avail_q >= CNT_W'(2));
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_WAIT:     if (in_valid) state_d = ST_DISPATCH;
			ST_DISPATCH: state_d = enough ? ST_ADDR_LO : ST_WAIT;
			ST_ADDR_LO:  state_d = ST_ADDR_HI;
			ST_ADDR_HI:  state_d = ST_EVAL;
			ST_EVAL: begin
				case (phase_q)
					PH_LENGTH: state_d = sub_q ? ST_DISPATCH : ST_ADDR_LO;
					PH_CHECK: begin
						if (sub_q)         state_d = ST_PUT;
						else if (!sync_hit) state_d = ST_DISPATCH;
						else if (len_zero)  state_d = ST_PUT;
						else                state_d = ST_ADDR_LO;
					end
					default: state_d = ST_DISPATCH;
				endcase
			end
			ST_PUT: begin
				if (load) state_d = put_last_q ? ST_DISPATCH : ST_ADDR_LO;
			end
			default: state_d = ST_WAIT;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready  = (state_q == ST_WAIT);
		load      = (state_q == ST_PUT) && (!out_valid_q || out_ready);
		ram_we    = in_valid && in_ready && !ring_full;
		ram_waddr = ring_add(rp_q, avail_q);
		ram_wdata = stream_byte;
		case (state_q)
			ST_ADDR_HI: ram_raddr = ring_add(rp_q, off_q + CNT_W'(1));
			default:    ram_raddr = ring_add(rp_q, off_q);
		endcase
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_WAIT;
			phase_q       <= PH_HEADER;
			rp_q          <= '0;
			fsp_q         <= '0;
			avail_q       <= '0;
			off_q         <= '0;
			held_len_q    <= '0;
			held_offset_q <= '0;
			loss_q        <= '0;
			first_q       <= 1'b0;
			sub_q         <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ram_we) begin
				avail_q <= avail_q + CNT_W'(1);
			end
			case (state_q)
				ST_DISPATCH: begin
					sub_q <= 1'b0;
					off_q <= (phase_q == PH_CHECK) ? held_len_q : '0;
				end
				ST_EVAL: begin
					case (phase_q)
						PH_LENGTH: begin
							if (!sub_q) begin
								held_offset_q <= word;
								off_q         <= CNT_W'(2);
								sub_q         <= 1'b1;
							end else if (len_reject) begin
								// rewind to just past the earlier sync word
								rp_q    <= ring_add(fsp_q, CNT_W'(2));
								phase_q <= PH_HEADER;
							end else begin
								rp_q       <= ring_add(rp_q, CNT_W'(4));
								avail_q    <= avail_q - CNT_W'(4);
								held_len_q <= CNT_W'(nbytes);
								phase_q    <= PH_CHECK;
							end
						end
						PH_CHECK: begin
							if (!sub_q) begin
								if (!sync_hit) begin
									rp_q    <= ring_add(fsp_q, CNT_W'(2));
									avail_q <= avail_q + CNT_W'(4);
									phase_q <= PH_HEADER;
									if (loss_q != LOSS_SAT) loss_q <= loss_q + 16'd1;
								end else if (!len_zero) begin
									off_q <= '0;
									sub_q <= 1'b1;
								end
							end
						end
						default: begin
							if (sync_hit) begin
								fsp_q   <= rp_q;
								rp_q    <= ring_add(rp_q, CNT_W'(2));
								avail_q <= avail_q - CNT_W'(2);
								phase_q <= PH_LENGTH;
							end else begin
								rp_q    <= ring_add(rp_q, CNT_W'(1));
								avail_q <= avail_q - CNT_W'(1);
								phase_q <= PH_HEADER;
								if (loss_q != LOSS_SAT) loss_q <= loss_q + 16'd1;
							end
						end
					endcase
				end
				ST_PUT: begin
					if (load) begin
						if (put_last_q) begin
							// frame done: the trailing sync word opens the next frame
							loss_q  <= '0;
							first_q <= 1'b1;
							fsp_q   <= ring_add(rp_q, held_len_q);
							rp_q    <= ring_add(rp_q, held_len_q + CNT_W'(2));
							avail_q <= avail_q - held_len_q - CNT_W'(2);
							phase_q <= PH_LENGTH;
						end else begin
							off_q <= off_q + CNT_W'(2);
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADDR_HI) begin
			lo_q <= ram_rdata;
		end
		if (state_q == ST_EVAL && phase_q == PH_CHECK) begin
			if (sub_q) begin
				put_word_q <= word;
				put_last_q <= off_last;
			end else begin
				put_word_q <= '0;
				put_last_q <= 1'b1;
			end
		end
		if (load) begin
			out_q.word_offset  <= held_offset_q;
			out_q.payload_word <= put_word_q;
			out_q.word_present <= !len_zero;
			out_q.lost_bytes   <= first_q ? loss_q : '0;
			out_q.loss_known   <= first_q;
			out_q.frame_last   <= put_last_q;
		end
	end

	a_avail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W+1)'(avail_q) <= RING_C)
		else $error("ring fill count beyond ring size");

	a_len_even: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CHECK) |-> (held_len_q[0] == 1'b0 &&
		(18'(held_len_q) + 18'd2) <= LIMIT_C))
		else $error("held payload length malformed");

	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		(load && put_last_q) |=> (phase_q == PH_LENGTH && loss_q == '0 && first_q))
		else $error("frame end did not reopen length phase");

	a_no_read_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL) |-> $past(state_q == ST_ADDR_HI))
		else $error("evaluate without a completed byte pair read");

endmodule
